// ----- rtl/core/ltc_pkg.sv -----
package ltc_pkg;

    localparam int CHAR_W  = 8;
    localparam int CLASS_W = 4;
    localparam int LEN_W   = 3;
    localparam int HEAD_N  = 6;
    localparam int REC_W   = 3;
    localparam int PHASE_W = 2;

    localparam logic [LEN_W-1:0] LEN_MAX = 3'd7;

    // Literal classes
    localparam logic [CLASS_W-1:0] CLS_NONE        = 4'd0;
    localparam logic [CLASS_W-1:0] CLS_INT         = 4'd1;
    localparam logic [CLASS_W-1:0] CLS_CHAR        = 4'd2;
    localparam logic [CLASS_W-1:0] CLS_UINT        = 4'd3;
    localparam logic [CLASS_W-1:0] CLS_LONG        = 4'd4;
    localparam logic [CLASS_W-1:0] CLS_ULONG       = 4'd5;
    localparam logic [CLASS_W-1:0] CLS_FLOAT       = 4'd6;
    localparam logic [CLASS_W-1:0] CLS_DOUBLE      = 4'd7;
    localparam logic [CLASS_W-1:0] CLS_LONG_DOUBLE = 4'd8;

    // Integer recognizer states
    localparam logic [REC_W-1:0] IS_START = 3'd0;
    localparam logic [REC_W-1:0] IS_SIGN  = 3'd1;
    localparam logic [REC_W-1:0] IS_ZERO  = 3'd2;
    localparam logic [REC_W-1:0] IS_HPFX  = 3'd3;
    localparam logic [REC_W-1:0] IS_HEX   = 3'd4;
    localparam logic [REC_W-1:0] IS_OCT   = 3'd5;
    localparam logic [REC_W-1:0] IS_DEC   = 3'd6;
    localparam logic [REC_W-1:0] IS_DEAD  = 3'd7;

    // Floating recognizer phases
    localparam logic [PHASE_W-1:0] PH_MANT = 2'd0;
    localparam logic [PHASE_W-1:0] PH_FRAC = 2'd1;
    localparam logic [PHASE_W-1:0] PH_EXP  = 2'd2;

    // Character codes
    localparam logic [CHAR_W-1:0] CH_QUOTE  = 8'h27;
    localparam logic [CHAR_W-1:0] CH_DQUOTE = 8'h22;
    localparam logic [CHAR_W-1:0] CH_BSLASH = 8'h5C;
    localparam logic [CHAR_W-1:0] CH_QMARK  = 8'h3F;
    localparam logic [CHAR_W-1:0] CH_PLUS   = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_DOT    = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_0      = 8'h30;
    localparam logic [CHAR_W-1:0] CH_7      = 8'h37;
    localparam logic [CHAR_W-1:0] CH_9      = 8'h39;
    localparam logic [CHAR_W-1:0] CH_UA     = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UE     = 8'h45;
    localparam logic [CHAR_W-1:0] CH_UF     = 8'h46;
    localparam logic [CHAR_W-1:0] CH_UL     = 8'h4C;
    localparam logic [CHAR_W-1:0] CH_UU     = 8'h55;
    localparam logic [CHAR_W-1:0] CH_LA     = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LB     = 8'h62;
    localparam logic [CHAR_W-1:0] CH_LF     = 8'h66;
    localparam logic [CHAR_W-1:0] CH_LN     = 8'h6E;
    localparam logic [CHAR_W-1:0] CH_LO     = 8'h6F;
    localparam logic [CHAR_W-1:0] CH_LR     = 8'h72;
    localparam logic [CHAR_W-1:0] CH_LT     = 8'h74;
    localparam logic [CHAR_W-1:0] CH_LV     = 8'h76;
    localparam logic [CHAR_W-1:0] CH_LX     = 8'h78;

    localparam logic [4*CHAR_W-1:0] TRUE_STR  = "true";
    localparam logic [5*CHAR_W-1:0] FALSE_STR = "false";

    typedef logic [CHAR_W-1:0] char_t;
    typedef logic [REC_W-1:0]  int_state_t;

    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        int_state_t         sub;
    } dbl_state_t;

    localparam dbl_state_t DS_START = '{phase: PH_MANT, sub: IS_START};
    localparam dbl_state_t DS_DEAD  = '{phase: PH_MANT, sub: IS_DEAD};

    // Token state as seen right after the newest item is folded in
    typedef struct packed {
        logic [LEN_W-1:0]        len;
        logic [HEAD_N-1:0][CHAR_W-1:0] head;
        char_t                   prev;
        char_t                   cur;
        int_state_t              int0;
        int_state_t              int1;
        int_state_t              int2;
        dbl_state_t              dbl0;
        dbl_state_t              dbl1;
    } tok_view_t;

    // Item handed from the input register to the token tracker
    typedef struct packed {
        logic  adv;
        logic  last;
        char_t code;
    } tok_step_t;

    function automatic logic is_dec(char_t c);
        return (c >= CH_0) && (c <= CH_9);
    endfunction

    function automatic logic is_oct(char_t c);
        return (c >= CH_0) && (c <= CH_7);
    endfunction

    function automatic logic is_hex(char_t c);
        return is_dec(c) || ((c >= CH_UA) && (c <= CH_UF)) || ((c >= CH_LA) && (c <= CH_LF));
    endfunction

    function automatic logic is_esc(char_t c);
        return (c == CH_0) || (c == CH_LA) || (c == CH_LB) || (c == CH_LF) ||
               (c == CH_LN) || (c == CH_LR) || (c == CH_LT) || (c == CH_LV) ||
               (c == CH_BSLASH) || (c == CH_QMARK) || (c == CH_QUOTE) || (c == CH_DQUOTE);
    endfunction

    function automatic logic int_acc(int_state_t s);
        return (s == IS_ZERO) || (s == IS_HEX) || (s == IS_OCT) || (s == IS_DEC);
    endfunction

    function automatic int_state_t int_next(int_state_t s, char_t c);
        int_state_t r;
        r = IS_DEAD;
        unique case (s)
            IS_START: begin
                if ((c == CH_PLUS) || (c == CH_MINUS)) r = IS_SIGN;
                else if (c == CH_0)                    r = IS_ZERO;
                else if (is_dec(c))                    r = IS_DEC;
            end
            IS_SIGN: begin
                if (c == CH_0)      r = IS_ZERO;
                else if (is_dec(c)) r = IS_DEC;
            end
            IS_ZERO: begin
                if (c == CH_LX)     r = IS_HPFX;
                else if (is_oct(c)) r = IS_OCT;
            end
            IS_HPFX, IS_HEX: begin
                if (is_hex(c)) r = IS_HEX;
            end
            IS_OCT: begin
                if (is_oct(c)) r = IS_OCT;
            end
            IS_DEC: begin
                if (is_dec(c)) r = IS_DEC;
            end
            default: r = IS_DEAD;
        endcase
        return r;
    endfunction

    function automatic logic dbl_acc(dbl_state_t d);
        return (d.phase <= PH_EXP) && int_acc(d.sub);
    endfunction

    function automatic dbl_state_t dbl_next(dbl_state_t d, char_t c);
        dbl_state_t r;
        r.phase = d.phase;
        r.sub   = int_next(d.sub, c);
        if (d.phase > PH_EXP) begin
            r = DS_DEAD;
        end else if (c == CH_DOT) begin
            if ((d.phase == PH_MANT) && int_acc(d.sub)) begin
                r.phase = PH_FRAC;
                r.sub   = IS_SIGN;
            end else begin
                r = DS_DEAD;
            end
        end else if ((c == CH_UE) && (d.phase != PH_EXP)) begin
            if (int_acc(d.sub)) begin
                r.phase = PH_EXP;
                r.sub   = IS_START;
            end else begin
                r = DS_DEAD;
            end
        end
        return r;
    endfunction

endpackage

// ----- rtl/core/literal_token_classifier.sv -----
// Channel  | Direction | Handshake          | Payload
// s_       | in        | s_valid / s_ready  | s_char_code[7:0], s_last_char
// m_       | out       | m_valid / m_ready  | m_literal_class[3:0]
//
// One item per cycle unless a final item waits for the output register.
// A final item's result is registered for m_valid; others give no result.
// Reset (aresetn low at a clock edge) empties both registers and the token.
// While a result waits, non-final items keep flowing; a final item waits in
// the input register until the output register frees.
module literal_token_classifier (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [ltc_pkg::CHAR_W-1:0]       s_char_code,
    input  logic                             s_last_char,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [ltc_pkg::CLASS_W-1:0]      m_literal_class
);

    logic                               in_valid_reg;
    ltc_pkg::char_t                     in_char_reg;
    logic                               in_last_reg;
    logic                               m_valid_reg;
    logic [ltc_pkg::CLASS_W-1:0]        m_class_reg;

    logic                               out_free;
    logic                               advance;
    logic                               s_accept;
    ltc_pkg::tok_step_t                 step;
    ltc_pkg::tok_view_t                 view;
    logic [ltc_pkg::CLASS_W-1:0]        class_next;

    assign out_free = !m_valid_reg || m_ready;
    assign advance  = in_valid_reg && (!in_last_reg || out_free);
    assign s_ready  = !in_valid_reg || advance;
    assign s_accept = s_valid && s_ready;

    assign step.adv  = advance;
    assign step.last = in_last_reg;
    assign step.code = in_char_reg;

    ltc_token_track u_track (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .view    (view)
    );

    ltc_class_decode u_decode (
        .view          (view),
        .literal_class (class_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_char_reg <= s_char_code;
            in_last_reg <= s_last_char;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance && in_last_reg) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_last_reg) begin
            m_class_reg <= class_next;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_literal_class = m_class_reg;

endmodule

// ----- rtl/core/ltc_token_track.sv -----
module ltc_token_track (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  ltc_pkg::tok_step_t   step,
    output ltc_pkg::tok_view_t   view
);

    logic [ltc_pkg::LEN_W-1:0]                         len_reg;
    logic [ltc_pkg::HEAD_N-1:0][ltc_pkg::CHAR_W-1:0]   head_reg;
    ltc_pkg::char_t                                    prev_reg;
    ltc_pkg::int_state_t                               int_cur_reg;
    ltc_pkg::int_state_t                               int_lag_reg;
    ltc_pkg::dbl_state_t                               dbl_cur_reg;

    ltc_pkg::tok_view_t view_next;

    always_comb begin
        view_next      = '0;
        view_next.len  = (len_reg < ltc_pkg::LEN_MAX) ? len_reg + 3'd1 : len_reg;
        view_next.head = head_reg;
        if (len_reg < 3'(ltc_pkg::HEAD_N)) begin
            view_next.head[len_reg] = step.code;
        end
        view_next.prev = prev_reg;
        view_next.cur  = step.code;
        view_next.int0 = ltc_pkg::int_next(int_cur_reg, step.code);
        view_next.int1 = int_cur_reg;
        view_next.int2 = int_lag_reg;
        view_next.dbl0 = ltc_pkg::dbl_next(dbl_cur_reg, step.code);
        view_next.dbl1 = dbl_cur_reg;
    end

    assign view = view_next;

    // Fold each item into the token; start over after the final one
    always_ff @(posedge aclk) begin
        if (!aresetn || (step.adv && step.last)) begin
            len_reg     <= '0;
            head_reg    <= '0;
            prev_reg    <= '0;
            int_cur_reg <= ltc_pkg::IS_START;
            int_lag_reg <= ltc_pkg::IS_START;
            dbl_cur_reg <= ltc_pkg::DS_START;
        end else if (step.adv) begin
            len_reg     <= view_next.len;
            head_reg    <= view_next.head;
            prev_reg    <= step.code;
            int_cur_reg <= view_next.int0;
            int_lag_reg <= int_cur_reg;
            dbl_cur_reg <= view_next.dbl0;
        end
    end

endmodule

// ----- rtl/core/ltc_class_decode.sv -----
module ltc_class_decode (
    input  ltc_pkg::tok_view_t                 view,
    output logic [ltc_pkg::CLASS_W-1:0]        literal_class
);

    logic                      bool_hit;
    logic                      char_hit;
    logic [ltc_pkg::LEN_W-1:0] close_idx;

    always_comb begin
        bool_hit = 1'b0;
        if (view.len == 3'd4) begin
            bool_hit = ({view.head[0], view.head[1], view.head[2], view.head[3]}
                        == ltc_pkg::TRUE_STR);
        end else if (view.len == 3'd5) begin
            bool_hit = ({view.head[0], view.head[1], view.head[2], view.head[3],
                         view.head[4]} == ltc_pkg::FALSE_STR);
        end
    end

    // Quoted char: plain, simple escape, hex or octal escape
    always_comb begin
        close_idx = view.len - 3'd1;
        char_hit  = 1'b0;
        if ((view.len >= 3'd3) && (view.len <= 3'd6) &&
            (view.head[0] == ltc_pkg::CH_QUOTE) &&
            (view.head[close_idx] == ltc_pkg::CH_QUOTE)) begin
            if (view.head[1] != ltc_pkg::CH_BSLASH) begin
                char_hit = (view.len == 3'd3) && (view.head[1] != ltc_pkg::CH_QUOTE);
            end else if (view.len == 3'd4) begin
                char_hit = ltc_pkg::is_esc(view.head[2]);
            end else if (view.len == 3'd6) begin
                if (view.head[2] == ltc_pkg::CH_LX) begin
                    char_hit = ltc_pkg::is_hex(view.head[3]) && ltc_pkg::is_hex(view.head[4]);
                end else if (view.head[2] == ltc_pkg::CH_LO) begin
                    char_hit = ltc_pkg::is_oct(view.head[3]) && ltc_pkg::is_oct(view.head[4]);
                end
            end
        end
    end

    always_comb begin
        if (bool_hit) begin
            literal_class = ltc_pkg::CLS_INT;
        end else if (char_hit) begin
            literal_class = ltc_pkg::CLS_CHAR;
        end else if (ltc_pkg::int_acc(view.int0)) begin
            literal_class = ltc_pkg::CLS_INT;
        end else if ((view.cur == ltc_pkg::CH_UU) && ltc_pkg::int_acc(view.int1)) begin
            literal_class = ltc_pkg::CLS_UINT;
        end else if ((view.cur == ltc_pkg::CH_UL) && ltc_pkg::int_acc(view.int1)) begin
            literal_class = ltc_pkg::CLS_LONG;
        end else if ((view.cur == ltc_pkg::CH_UL) && (view.prev == ltc_pkg::CH_UU) &&
                     ltc_pkg::int_acc(view.int2)) begin
            literal_class = ltc_pkg::CLS_ULONG;
        end else if ((view.cur == ltc_pkg::CH_UF) && ltc_pkg::dbl_acc(view.dbl1)) begin
            literal_class = ltc_pkg::CLS_FLOAT;
        end else if (ltc_pkg::dbl_acc(view.dbl0)) begin
            literal_class = ltc_pkg::CLS_DOUBLE;
        end else if ((view.cur == ltc_pkg::CH_UL) && ltc_pkg::dbl_acc(view.dbl1)) begin
            literal_class = ltc_pkg::CLS_LONG_DOUBLE;
        end else begin
            literal_class = ltc_pkg::CLS_NONE;
        end
    end

endmodule

// ----- rtl/core/ltc_checker.sv -----
module ltc_checker (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    input  logic                             s_ready,
    input  logic [ltc_pkg::CHAR_W-1:0]       s_char_code,
    input  logic                             s_last_char,
    input  logic                             m_valid,
    input  logic                             m_ready,
    input  logic [ltc_pkg::CLASS_W-1:0]      m_literal_class
);

    // Pipeline is empty right after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // A new result must come from an accepted final item
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready && s_last_char, 2))
        else $error("result without a final item");

    a_class_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_literal_class <= ltc_pkg::CLS_LONG_DOUBLE))
        else $error("class code out of range");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_literal_class))
        else $error("stalled result changed");

    // Hold the offered item until it is taken
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_char_code) && $stable(s_last_char))
        else $error("stalled input item changed");

endmodule

bind literal_token_classifier ltc_checker u_ltc_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_valid         (s_valid),
    .s_ready         (s_ready),
    .s_char_code     (s_char_code),
    .s_last_char     (s_last_char),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_literal_class (m_literal_class)
);
